// ===== design/assert_macros.svh =====
// Assertion macros for the checker file of this block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define LUCW_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define LUCW_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== design/lucw_pkg.sv =====
// Fixed widths and constants of the longest repeat-free window block.
// Depends on nothing; imported by every module of the block.
package lucw_pkg;

   // character code width and number of codes it can carry
   localparam int CH_W     = 7;
   localparam int CH_CODES = 128;

   // string tag held with each last-seen entry
   localparam int TAG_W = 8;

   // width of the length fields on the result channel
   localparam int LEN_W = 16;

endpackage

// ===== design/lucw_seen_table.sv =====
// Last-seen table: synchronous memory of {tag, position} per character,
// with per-entry valid flops and write-to-read forwarding. Uses lucw_pkg.
module lucw_seen_table
   import lucw_pkg::*;
#(
   parameter int ALPHABET = 128,
   parameter int IDX_W    = 7,
   parameter int POS_W    = 16
) (
   input  logic             clock,
   input  logic             reset,
   // read issued when a transaction is accepted
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_idx,
   // index of the transaction in the update stage
   input  logic [IDX_W-1:0] cur_idx,
   // write-back from the update stage
   input  logic             wr_en,
   input  logic [TAG_W-1:0] wr_tag,
   input  logic [POS_W-1:0] wr_pos,
   input  logic             clear_all,
   // entry seen by the transaction in the update stage
   output logic             ent_valid,
   output logic [TAG_W-1:0] ent_tag,
   output logic [POS_W-1:0] ent_pos
);

   localparam int ENT_W = TAG_W + POS_W;

   logic [ENT_W-1:0]    seen_mem_ff [ALPHABET];
   logic [ENT_W-1:0]    rd_data_ff;
   logic [ENT_W-1:0]    fwd_data_ff;
   logic                fwd_sel_ff;
   logic                fwd_sel_in;
   logic [ALPHABET-1:0] valid_ff;
   logic [ALPHABET-1:0] valid_in;
   logic [ENT_W-1:0]    ent_data;

   function automatic logic wr_idx_eq(input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b);
      return a == b;
   endfunction

   // memory write port, written back from the update stage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         seen_mem_ff[cur_idx] <= {wr_tag, wr_pos};
      end
   end

   // memory read port; a write to the same entry on the same edge is forwarded
   assign fwd_sel_in = wr_en && (wr_idx_eq(cur_idx, rd_idx));

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= seen_mem_ff[rd_idx];
         fwd_data_ff <= {wr_tag, wr_pos};
         fwd_sel_ff  <= fwd_sel_in;
      end
   end

   // valid flags: cleared at reset and on tag wrap, set by each write
   always_comb begin
      valid_in = valid_ff;
      if (clear_all) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[cur_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ent_data  = fwd_sel_ff ? fwd_data_ff : rd_data_ff;
   assign ent_valid = valid_ff[cur_idx];
   assign ent_tag   = ent_data[ENT_W-1:POS_W];
   assign ent_pos   = ent_data[POS_W-1:0];

endmodule

// ===== design/longest_unique_char_window.sv =====
// Longest repeat-free window: takes one character per transaction and returns, per character,
// the length of the repeat-free window ending there and the best such length of the string so
// far; end_of_string marks the last character, whose result carries final_res and after which
// the next string starts clean. One transaction is accepted every clock cycle while the output
// is not stalled; it passes through the update stage into the output register. The last-seen
// table read is synchronous and issued at acceptance, then compare, update and write-back
// follow in the update stage, with the write of the previous character forwarded to the read.
// Table entries carry a string tag, so a string end costs no table sweep; when the tag wraps
// all valid flags clear at once. Lengths are tracked in ceil(log2(MAX_LEN+1)) bits and reported
// in 16 bits.
// Depends on lucw_pkg and lucw_seen_table.
module longest_unique_char_window
   import lucw_pkg::*;
#(
   parameter int ALPHABET = 128,
   parameter int MAX_LEN  = 65535
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [CH_W-1:0]  req_ch,
   input  logic             req_end_of_string,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [LEN_W-1:0] rsp_best_length,
   output logic [LEN_W-1:0] rsp_window_length,
   output logic             rsp_final_res
);

   localparam int IDX_W = $clog2(ALPHABET);
   localparam int POS_W = $clog2(MAX_LEN + 1);
   localparam logic [POS_W-1:0] MAX_P = POS_W'(MAX_LEN);
   localparam logic [POS_W:0]   MAX_X = (POS_W + 1)'(MAX_LEN);

   // character code to table index (code modulo ALPHABET), worked out at elaboration
   logic [IDX_W-1:0] ch_mod [CH_CODES];

   for (genvar g = 0; g < CH_CODES; g++) begin : g_mod
      assign ch_mod[g] = IDX_W'(g % ALPHABET);
   end

   // handshake
   logic             req_fire;
   logic             upd_fire;
   logic             upd_valid_ff;
   logic             upd_valid_in;
   logic [IDX_W-1:0] upd_idx_ff;
   logic             upd_last_ff;

   // per-string state
   logic [TAG_W-1:0] tag_ff,   tag_in;
   logic [POS_W-1:0] pos_ff,   pos_in;
   logic [POS_W-1:0] start_ff, start_in;
   logic [POS_W-1:0] best_ff,  best_in;

   // table lookup result
   logic             ent_valid;
   logic [TAG_W-1:0] ent_tag;
   logic [POS_W-1:0] ent_pos;
   logic             clear_all;

   // update stage datapath
   logic             hit;
   logic [POS_W:0]   start_x;
   logic [POS_W-1:0] start_c;
   logic [POS_W:0]   wlen_x;
   logic [POS_W-1:0] wlen;
   logic [POS_W-1:0] best_next;

   // output register
   logic             rsp_valid_ff;
   logic [LEN_W-1:0] rsp_best_ff;
   logic [LEN_W-1:0] rsp_wlen_ff;
   logic             rsp_final_ff;

   assign upd_fire  = upd_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = upd_valid_ff && !upd_fire;
   assign req_fire  = req_valid && !req_stall;

   // update stage holds one transaction whose table read is in flight
   always_comb begin
      upd_valid_in = upd_valid_ff;
      if (req_fire) begin
         upd_valid_in = 1'b1;
      end else if (upd_fire) begin
         upd_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upd_valid_ff <= 1'b0;
      end else begin
         upd_valid_ff <= upd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         upd_idx_ff  <= ch_mod[req_ch];
         upd_last_ff <= req_end_of_string;
      end
   end

   assign clear_all = upd_fire && upd_last_ff && (tag_ff == {TAG_W{1'b1}});

   lucw_seen_table #(
      .ALPHABET (ALPHABET),
      .IDX_W    (IDX_W),
      .POS_W    (POS_W)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_fire),
      .rd_idx    (ch_mod[req_ch]),
      .cur_idx   (upd_idx_ff),
      .wr_en     (upd_fire),
      .wr_tag    (tag_ff),
      .wr_pos    (pos_ff),
      .clear_all (clear_all),
      .ent_valid (ent_valid),
      .ent_tag   (ent_tag),
      .ent_pos   (ent_pos)
   );

   // window start moves past the last sighting, never beyond the current index
   always_comb begin
      hit     = ent_valid && (ent_tag == tag_ff) && (ent_pos >= start_ff);
      start_x = hit ? ({1'b0, ent_pos} + (POS_W + 1)'(1)) : {1'b0, start_ff};
      start_c = (start_x > {1'b0, pos_ff}) ? pos_ff : start_x[POS_W-1:0];
      wlen_x  = {1'b0, pos_ff} - {1'b0, start_c} + (POS_W + 1)'(1);
      wlen    = (wlen_x > MAX_X) ? MAX_P : wlen_x[POS_W-1:0];
      best_next = (wlen > best_ff) ? wlen : best_ff;
   end

   // string state: tag advanced and the rest cleared after the last character, else advanced
   always_comb begin
      tag_in   = tag_ff;
      pos_in   = pos_ff;
      start_in = start_ff;
      best_in  = best_ff;
      if (upd_fire) begin
         if (upd_last_ff) begin
            tag_in   = tag_ff + TAG_W'(1);
            pos_in   = '0;
            start_in = '0;
            best_in  = '0;
         end else begin
            pos_in   = (pos_ff == MAX_P) ? pos_ff : pos_ff + POS_W'(1);
            start_in = start_c;
            best_in  = best_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff   <= '0;
         pos_ff   <= '0;
         start_ff <= '0;
         best_ff  <= '0;
      end else begin
         tag_ff   <= tag_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         best_ff  <= best_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (upd_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (upd_fire) begin
         rsp_best_ff  <= LEN_W'(best_next);
         rsp_wlen_ff  <= LEN_W'(wlen);
         rsp_final_ff <= upd_last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_best_length   = rsp_best_ff;
   assign rsp_window_length = rsp_wlen_ff;
   assign rsp_final_res     = rsp_final_ff;

endmodule

// ===== design/lucw_checker.sv =====
// Port-level checker for the longest repeat-free window block, bound to the top level.
// Depends on lucw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lucw_checker
   import lucw_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic [CH_W-1:0]  req_ch,
   input logic             req_end_of_string,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [LEN_W-1:0] rsp_best_length,
   input logic [LEN_W-1:0] rsp_window_length,
   input logic             rsp_final_res
);

   logic             req_fire;
   logic             rsp_fire;
   logic [2:0]       pend_ff;
   logic [2:0]       pend_in;
   logic             first_ff;
   logic             req_wait;
   logic             rsp_wait;
   logic [CH_W:0]    req_data;
   logic [2*LEN_W:0] rsp_data;
   logic             first_rsp;
   logic             unit_lens;

   assign req_fire = req_valid && !req_stall;
   assign rsp_fire = rsp_valid && !rsp_stall;

   // stalled payloads and the first result of a string
   assign req_wait  = req_valid && req_stall;
   assign rsp_wait  = rsp_valid && rsp_stall;
   assign req_data  = {req_ch, req_end_of_string};
   assign rsp_data  = {rsp_best_length, rsp_window_length, rsp_final_res};
   assign first_rsp = rsp_valid && first_ff;
   assign unit_lens = (rsp_best_length == LEN_W'(1)) && (rsp_window_length == LEN_W'(1));

   // transactions accepted but not yet delivered
   always_comb begin
      pend_in = pend_ff;
      if (req_fire && !rsp_fire) begin
         pend_in = pend_ff + 3'd1;
      end else if (rsp_fire && !req_fire) begin
         pend_in = pend_ff - 3'd1;
      end
   end

   // next result opens a new string
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         first_ff <= 1'b1;
      end else begin
         pend_ff <= pend_in;
         if (rsp_fire) begin
            first_ff <= rsp_final_res;
         end
      end
   end

   `LUCW_ASSERT(a_req_hold, clock, reset, req_wait |=> req_valid && $stable(req_data), "req moved")
   `LUCW_ASSERT(a_rsp_hold, clock, reset, rsp_wait |=> rsp_valid && $stable(rsp_data), "rsp moved")
   `LUCW_ASSERT(a_first_char, clock, reset, first_rsp |-> unit_lens, "first length not one")
   `LUCW_NEVER(a_pend_max, clock, reset, pend_ff > 3'd2, "more than two transactions in flight")
   `LUCW_NEVER(a_no_phantom, clock, reset, rsp_valid && pend_ff == 3'd0, "orphan result")

endmodule

bind longest_unique_char_window lucw_checker u_lucw_checker (.*);
